// ===== sv/tse_pkg.sv =====
package tse_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int BND_W = IDX_W + 2;
	localparam int CNT_W = 11;
	localparam int POS_W = 10;
	localparam int DATA_W = 32;

	localparam int RECIP_SH = IDX_W + 2;
	localparam int RECIP_W = RECIP_SH;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SH) / 3 + 1);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam int REG_ELEMENT_COUNT = 0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RANGE,
		ST_PROBE,
		ST_CMP
	} tse_state_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr_a;
		logic [IDX_W-1:0]  raddr_b;
	} tse_ram_req_t;

endpackage

// ===== sv/tse_store.sv =====
module tse_store import tse_pkg::*; (
	input  logic              clk,
	input  tse_ram_req_t      req,
	output logic [DATA_W-1:0] rd_a,
	output logic [DATA_W-1:0] rd_b
);

	logic [DATA_W-1:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_a <= mem[req.raddr_a];
		rd_b <= mem[req.raddr_b];
	end

endmodule

// ===== sv/tse_ctrl.sv =====
module tse_ctrl import tse_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     command,
	input  logic        [POS_W-1:0]  load_position,
	input  logic signed [DATA_W-1:0] value,
	input  logic        [CNT_W-1:0]  element_count,
	input  logic signed [DATA_W-1:0] rd_a,
	input  logic signed [DATA_W-1:0] rd_b,
	output tse_ram_req_t             req,
	output logic                     busy,
	output logic                     done,
	output logic                     found,
	output logic        [POS_W-1:0]  position
);

	tse_state_t state_q, state_d;

	logic signed [BND_W-1:0]  lo_q, lo_d;
	logic signed [BND_W-1:0]  hi_q, hi_d;
	logic        [IDX_W-1:0]  third_q, third_d;
	logic        [IDX_W-1:0]  m1_q, m1_d;
	logic        [IDX_W-1:0]  m2_q, m2_d;
	logic signed [DATA_W-1:0] key_q, key_d;
	logic                     done_q, done_d;
	logic                     found_q, found_d;
	logic        [POS_W-1:0]  pos_q, pos_d;

	logic signed [BND_W-1:0]       diff;
	logic [IDX_W+RECIP_W-1:0]      prod;
	logic signed [BND_W-1:0]       m1_full;
	logic signed [BND_W-1:0]       m2_full;
	logic [31:0]                   cnt_sat;
	logic signed [BND_W-1:0]       m1_ext;
	logic signed [BND_W-1:0]       m2_ext;

	assign diff = hi_q - lo_q;
	assign prod = (IDX_W+RECIP_W)'(diff[IDX_W-1:0]) * (IDX_W+RECIP_W)'(RECIP);
	assign m1_full = lo_q + BND_W'(third_q);
	assign m2_full = hi_q - BND_W'(third_q);
	assign m1_ext = BND_W'(m1_q);
	assign m2_ext = BND_W'(m2_q);
	assign cnt_sat = (32'(element_count) > 32'(STORE_DEPTH)) ? 32'(STORE_DEPTH)
		: 32'(element_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
			lo_q <= '0;
			hi_q <= '0;
		end else begin
			state_q <= state_d;
			done_q <= done_d;
			lo_q <= lo_d;
			hi_q <= hi_d;
		end
	end

	always_ff @(posedge clk) begin
		third_q <= third_d;
		m1_q <= m1_d;
		m2_q <= m2_d;
		key_q <= key_d;
		found_q <= found_d;
		pos_q <= pos_d;
	end

	always_comb begin
		state_d = state_q;
		lo_d = lo_q;
		hi_d = hi_q;
		third_d = third_q;
		m1_d = m1_q;
		m2_d = m2_q;
		key_d = key_q;
		done_d = 1'b0;
		found_d = found_q;
		pos_d = pos_q;
		req.we = 1'b0;
		req.waddr = IDX_W'(load_position);
		req.wdata = value;
		req.raddr_a = m1_full[IDX_W-1:0];
		req.raddr_b = m2_full[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (command == CMD_LOAD) begin
						req.we = (32'(load_position) < 32'(STORE_DEPTH));
					end else begin
						key_d = value;
						lo_d = '0;
						hi_d = BND_W'(cnt_sat) - BND_W'(1);
						state_d = ST_RANGE;
					end
				end
			end
			ST_RANGE: begin
				if (lo_q > hi_q) begin
					done_d = 1'b1;
					found_d = 1'b0;
					pos_d = '0;
					state_d = ST_IDLE;
				end else begin
					third_d = prod[RECIP_SH +: IDX_W];
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				m1_d = m1_full[IDX_W-1:0];
				m2_d = m2_full[IDX_W-1:0];
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (rd_a == key_q) begin
					done_d = 1'b1;
					found_d = 1'b1;
					pos_d = POS_W'(m1_q);
					state_d = ST_IDLE;
				end else if (rd_b == key_q) begin
					done_d = 1'b1;
					found_d = 1'b1;
					pos_d = POS_W'(m2_q);
					state_d = ST_IDLE;
				end else begin
					if (key_q < rd_a) begin
						hi_d = m1_ext - BND_W'(1);
					end else if (key_q > rd_b) begin
						lo_d = m2_ext + BND_W'(1);
					end else begin
						lo_d = m1_ext + BND_W'(1);
						hi_d = m2_ext - BND_W'(1);
					end
					state_d = ST_RANGE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign found = found_q;
	assign position = pos_q;

endmodule

// ===== sv/ternary_search_engine.sv =====
// a load is written at its accept edge and gives no result
// a search runs narrowing rounds (bound, probe, compare) until it hits or the range empties,
// at most 7 rounds for 1024 entries; busy while running
// a new request is taken in the result cycle, one search at a time
// result is a 1-cycle strobe on done; the receiver cannot stall
// arst_n clears control and element_count; store contents are undefined until loaded
module ternary_search_engine import tse_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     command,
	input  logic        [POS_W-1:0]  load_position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic                     found,
	output logic        [POS_W-1:0]  position,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic        [2:0]        paddr,
	input  logic        [31:0]       pwdata,
	output logic        [31:0]       prdata,
	output logic                     pready
);

	logic [CNT_W-1:0]  element_count_q;
	tse_ram_req_t      req;
	logic [DATA_W-1:0] rd_a;
	logic [DATA_W-1:0] rd_b;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready
		&& (paddr == 3'(4 * REG_ELEMENT_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= '0;
		end else if (wr_en) begin
			element_count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr == 3'(4 * REG_ELEMENT_COUNT)) ? 32'(element_count_q) : 32'd0;

	tse_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.command       (command),
		.load_position (load_position),
		.value         (value),
		.element_count (element_count_q),
		.rd_a          (rd_a),
		.rd_b          (rd_b),
		.req           (req),
		.busy          (busy),
		.done          (done),
		.found         (found),
		.position      (position)
	);

	tse_store u_store (
		.clk  (clk),
		.req  (req),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

endmodule

// ===== sv/tse_checker.sv =====
module tse_checker import tse_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             command,
	input logic             done,
	input logic             found,
	input logic [POS_W-1:0] position
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> position == '0)
		else $error("not-found result with nonzero position");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_LOAD |=> !done && !busy)
		else $error("load request produced a result or went busy");

	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_SEARCH |=> busy && !done)
		else $error("search request did not start");

endmodule

bind ternary_search_engine tse_checker u_tse_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.command  (command),
	.done     (done),
	.found    (found),
	.position (position)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import tse_pkg::*;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} search_hit_t;

	localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     command;
	logic        [POS_W-1:0]  load_position;
	logic signed [DATA_W-1:0] value;
	logic                     done;
	logic                     found;
	logic        [POS_W-1:0]  position;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic        [2:0]        paddr;
	logic        [31:0]       pwdata;
	logic        [31:0]       prdata;
	logic                     pready;

	logic signed [DATA_W-1:0] store_model [STORE_DEPTH];
	int unsigned              count_model = 0;
	search_hit_t              pending_hits [$];
	int                       gap_pct = 0;
	int                       mismatches = 0;
	int                       n_loads = 0;
	int                       n_searches = 0;
	int                       n_hits = 0;
	int                       n_cfg = 0;

	ternary_search_engine i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.load_position (load_position),
		.value         (value),
		.done          (done),
		.found         (found),
		.position      (position),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #10 clk = ~clk;

	task automatic note_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
	endtask

	// ternary search over the modeled store
	function automatic search_hit_t predict_search(input logic signed [DATA_W-1:0] key);
		search_hit_t res;
		int          lo;
		int          hi;
		int          third;
		int          m1;
		int          m2;
		res = '0;
		lo = 0;
		hi = ((count_model > STORE_DEPTH) ? STORE_DEPTH : int'(count_model)) - 1;
		while (lo <= hi && !res.found) begin
			third = (hi - lo) / 3;
			m1 = lo + third;
			m2 = hi - third;
			if (store_model[m1] == key) begin
				res.found = 1'b1;
				res.position = POS_W'(m1);
			end else if (store_model[m2] == key) begin
				res.found = 1'b1;
				res.position = POS_W'(m2);
			end else if (key < store_model[m1]) begin
				hi = m1 - 1;
			end else if (key > store_model[m2]) begin
				lo = m2 + 1;
			end else begin
				lo = m1 + 1;
				hi = m2 - 1;
			end
		end
		return res;
	endfunction

	always @(posedge clk) begin
		search_hit_t got;
		search_hit_t want;
		if (arst_n && done) begin
			got.found = found;
			got.position = position;
			if (got.found)
				n_hits++;
			if (pending_hits.size() == 0) begin
				note_mismatch("unexpected result", 64'h0, 64'(got));
			end else begin
				want = pending_hits.pop_front();
				if (got.found !== want.found)
					note_mismatch("found", 64'(want.found), 64'(got.found));
				if (got.position !== want.position)
					note_mismatch("position", 64'(want.position), 64'(got.position));
			end
		end
	end

	function automatic logic signed [DATA_W-1:0] rand_word();
		logic signed [DATA_W-1:0] w;
		w = $urandom;
		return w;
	endfunction

	task automatic send_req(input logic cmd, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		load_position <= pos;
		value <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (cmd == CMD_LOAD) begin
			store_model[pos] = val;
			n_loads++;
		end else begin
			pending_hits.push_back(predict_search(val));
			n_searches++;
		end
	endtask

	// let in-flight searches finish before touching the register
	task automatic settle();
		start <= 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (40)
			@(posedge clk);
	endtask

	task automatic write_count(input logic [31:0] cnt);
		logic [31:0] rd;
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(REG_ELEMENT_COUNT * 4);
		pwdata <= cnt;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		count_model = cnt & 32'h7FF;
		n_cfg++;
		// read back
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd[CNT_W-1:0] !== count_model[CNT_W-1:0])
			note_mismatch("element_count readback", 64'(count_model), 64'(rd));
	endtask

	// ascending values from position 0, dense runs give duplicates
	task automatic load_sorted(input int n, input bit dense);
		longint acc;
		longint span;
		acc = dense ? longint'(rand_word()) : -64'sd2147483648 + $urandom_range(1000);
		span = dense ? 3 : 64'sd4294967296 / (n + 1);
		for (int i = 0; i < n; i++) begin
			if (acc > 64'sd2147483647)
				acc = 64'sd2147483647;
			send_req(CMD_LOAD, POS_W'(i), DATA_W'(acc));
			acc += $urandom_range(32'(span), 0);
		end
	endtask

	function automatic logic signed [DATA_W-1:0] pick_key();
		int          n;
		int unsigned r;
		logic signed [DATA_W-1:0] e;
		n = (count_model > STORE_DEPTH) ? STORE_DEPTH : int'(count_model);
		if (n == 0)
			return rand_word();
		r = $urandom_range(99);
		e = store_model[$urandom_range(n - 1)];
		if (r < 55)
			return e;
		if (r < 65)
			return e + 1;
		if (r < 75)
			return e - 1;
		if (r < 80)
			return WORD_MIN;
		if (r < 85)
			return WORD_MAX;
		return rand_word();
	endfunction

	task automatic run_searches(input int k);
		for (int j = 0; j < k; j++) begin
			if ($urandom_range(99) < 8)
				send_req(CMD_LOAD, POS_W'($urandom_range(STORE_DEPTH - 1)), rand_word());
			else
				send_req(CMD_SEARCH, POS_W'($urandom_range(STORE_DEPTH - 1)), pick_key());
		end
	endtask

	task automatic test_directed();
		// empty array after reset
		send_req(CMD_SEARCH, '0, 32'sd0);
		send_req(CMD_SEARCH, '1, WORD_MIN);
		send_req(CMD_LOAD, '0, WORD_MIN);
		write_count(1);
		send_req(CMD_SEARCH, '0, WORD_MIN);
		send_req(CMD_SEARCH, '0, WORD_MAX);
		send_req(CMD_LOAD, 10'd1, -32'sd1000);
		send_req(CMD_LOAD, 10'd2, -32'sd1);
		send_req(CMD_LOAD, 10'd3, 32'sd0);
		send_req(CMD_LOAD, 10'd4, 32'sd1);
		send_req(CMD_LOAD, 10'd5, 32'sd5);
		send_req(CMD_LOAD, 10'd6, 32'sd5);
		send_req(CMD_LOAD, 10'd7, 32'sd77);
		send_req(CMD_LOAD, 10'd8, 32'sd1000000);
		send_req(CMD_LOAD, 10'd9, WORD_MAX);
		write_count(10);
		send_req(CMD_SEARCH, '0, WORD_MAX);
		send_req(CMD_SEARCH, '0, 32'sd0);
		send_req(CMD_SEARCH, '0, 32'sd5);
		send_req(CMD_SEARCH, '0, 32'sd6);
		send_req(CMD_SEARCH, '0, WORD_MIN + 1);
		send_req(CMD_LOAD, '1, 32'sd42);
		// break the ordering
		send_req(CMD_LOAD, 10'd4, 32'sd999);
		send_req(CMD_SEARCH, '0, 32'sd999);
		write_count(0);
		send_req(CMD_SEARCH, '0, 32'sd5);
	endtask

	task automatic test_full_store();
		load_sorted(STORE_DEPTH, 1'b0);
		// count above the store depth saturates
		write_count(32'h7FF);
		run_searches(20);
		write_count(STORE_DEPTH);
		run_searches(10);
		write_count(STORE_DEPTH + 1);
		run_searches(5);
	endtask

	// every position is written by now, so any count is safe
	task automatic test_random_phases(input int pct, input int phases);
		int          n;
		int unsigned r;
		gap_pct = pct;
		for (int p = 0; p < phases; p++) begin
			r = $urandom_range(99);
			if (r < 10) begin
				write_count(0);
			end else if (r < 20) begin
				write_count($urandom_range(2047, 1));
			end else if (r < 30) begin
				n = $urandom_range(40, 1);
				for (int i = 0; i < n; i++)
					send_req(CMD_LOAD, POS_W'(i), rand_word());
				write_count(n);
			end else begin
				n = $urandom_range(48, 1);
				load_sorted(n, $urandom_range(1, 0));
				write_count(n);
			end
			run_searches($urandom_range(30, 15));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		command <= CMD_LOAD;
		load_position <= '0;
		value <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 14;
		test_directed();
		test_full_store();
		test_random_phases(14, 2);
		test_random_phases(49, 2);
		test_random_phases(0, 2);
		settle();
		$display("covered %0d loads and %0d searches (%0d found), %0d register writes",
			n_loads, n_searches, n_hits, n_cfg);
		$display("element counts from zero up to saturation, sorted and unsorted stores");
		if (mismatches == 0 && pending_hits.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/tse_pkg.sv
sv/tse_store.sv
sv/tse_ctrl.sv
sv/ternary_search_engine.sv
sv/tse_checker.sv
sim/tb_top.sv
